[rtl/uart_query_responder_macros.svh]
// Assertion macros used by the checker of this block
`ifndef UART_QUERY_RESPONDER_MACROS_SVH
`define UART_QUERY_RESPONDER_MACROS_SVH

// Same-cycle implication, clocked on clock, off during reset
`define UQR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset
`define UQR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/uqr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package uqr_pkg;

   localparam int RX_DEPTH_DEF  = 16;
   localparam int TX_DEPTH_DEF  = 16;
   localparam int NUM_QUERIES   = 5;
   localparam int MAX_MSG_BYTES = 5;

   localparam int TPB_W = 4;
   localparam int TMO_W = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam int QI_W = (NUM_QUERIES > 1) ? $clog2(NUM_QUERIES) : 1;
   localparam int MJ_W = (MAX_MSG_BYTES > 1) ? $clog2(MAX_MSG_BYTES) : 1;
   localparam int LEN_W = 4;

   localparam logic [TPB_W-1:0] TPB_RESET = 4'd4;
   localparam logic [TMO_W-1:0] TMO_RESET = 16'd480;

   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_BIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT_TICKS = 1'd1;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_START  = 3'd1,
      PH_DATA   = 3'd2,
      PH_PARITY = 3'd3,
      PH_STOP   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_FETCH  = 3'd1,
      ST_STEP   = 3'd2,
      ST_MATCH  = 3'd3,
      ST_APPEND = 3'd4,
      ST_FINISH = 3'd5
   } ctrl_state_type;

   typedef struct packed {
      logic accept;
      logic fetch;
      logic step;
      logic eval;
      logic append;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic match_req;
      logic q_short;
      logic q_hit;
      logic q_fit;
      logic q_last;
      logic app_last;
   } status_type;

   // Query and reply table
   localparam logic [LEN_W-1:0] QRY_LEN [NUM_QUERIES] = '{4'd2, 4'd3, 4'd2, 4'd2, 4'd3};
   localparam logic [7:0] QRY_BYTES [NUM_QUERIES][MAX_MSG_BYTES] = '{
      '{8'h51, 8'h0D, 8'h00, 8'h00, 8'h00},
      '{8'h4C, 8'h46, 8'h0D, 8'h00, 8'h00},
      '{8'h50, 8'h0D, 8'h00, 8'h00, 8'h00},
      '{8'h51, 8'h0D, 8'h00, 8'h00, 8'h00},
      '{8'h4C, 8'h45, 8'h0D, 8'h00, 8'h00}
   };
   localparam logic [LEN_W-1:0] RSP_LEN [NUM_QUERIES] = '{4'd3, 4'd2, 4'd3, 4'd3, 4'd2};
   localparam logic [7:0] RSP_BYTES [NUM_QUERIES][MAX_MSG_BYTES] = '{
      '{8'h51, 8'h32, 8'h0D, 8'h00, 8'h00},
      '{8'h41, 8'h0D, 8'h00, 8'h00, 8'h00},
      '{8'h50, 8'h46, 8'h0D, 8'h00, 8'h00},
      '{8'h51, 8'h32, 8'h0D, 8'h00, 8'h00},
      '{8'h41, 8'h0D, 8'h00, 8'h00, 8'h00}
   };

endpackage
`default_nettype wire

[rtl/uqr_req_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface uqr_req_if;
   logic valid;
   logic ready;
   logic rx_level;
   modport source (output valid, output rx_level, input ready);
   modport sink (input valid, input rx_level, output ready);
endinterface
`default_nettype wire

[rtl/uqr_rsp_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface uqr_rsp_if;
   logic valid;
   logic ready;
   logic tx_level;
   logic byte_received;
   logic reply_queued;
   modport source (output valid, output tx_level, output byte_received,
                   output reply_queued, input ready);
   modport sink (input valid, input tx_level, input byte_received,
                 input reply_queued, output ready);
endinterface
`default_nettype wire

[rtl/uqr_csr_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface uqr_csr_if;
   logic                              valid;
   logic                              ready;
   logic [uqr_pkg::CSR_IDX_W-1:0]     index;
   logic [uqr_pkg::CSR_DATA_W-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

[rtl/uqr_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module uqr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire uqr_pkg::status_type  status,
   output uqr_pkg::cmd_type          cmd
);

   uqr_pkg::ctrl_state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= uqr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         uqr_pkg::ST_IDLE: begin
            req_ready = status.rsp_free;
            if (req_valid && status.rsp_free) begin
               cmd.accept = 1'b1;
               state_in   = uqr_pkg::ST_FETCH;
            end
         end
         uqr_pkg::ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = uqr_pkg::ST_STEP;
         end
         uqr_pkg::ST_STEP: begin
            cmd.step = 1'b1;
            state_in = uqr_pkg::ST_MATCH;
         end
         uqr_pkg::ST_MATCH: begin
            if (!status.match_req) begin
               state_in = uqr_pkg::ST_FINISH;
            end else begin
               cmd.eval = 1'b1;
               if (status.q_hit) begin
                  state_in = status.q_fit ? uqr_pkg::ST_APPEND : uqr_pkg::ST_FINISH;
               end else if (status.q_last) begin
                  state_in = uqr_pkg::ST_FINISH;
               end
            end
         end
         uqr_pkg::ST_APPEND: begin
            cmd.append = 1'b1;
            if (status.app_last) begin
               state_in = uqr_pkg::ST_FINISH;
            end
         end
         uqr_pkg::ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = uqr_pkg::ST_IDLE;
         end
         default: begin
            state_in = uqr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

[rtl/uqr_dpath.sv]
`timescale 1ns / 1ps
`default_nettype none
module uqr_dpath #(
   parameter int RX_DEPTH = uqr_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = uqr_pkg::TX_DEPTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire uqr_pkg::cmd_type               cmd,
   output uqr_pkg::status_type                 status,
   input  wire logic                           req_rx_level,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic                                rsp_tx_level,
   output logic                                rsp_byte_received,
   output logic                                rsp_reply_queued,
   input  wire logic                           csr_valid,
   input  wire logic [uqr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [uqr_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int RXC_W = $clog2(RX_DEPTH);
   localparam int TXP_W = $clog2(TX_DEPTH);
   localparam int SUM_W = TXP_W + uqr_pkg::LEN_W;
   localparam int CMP_W = RXC_W + uqr_pkg::LEN_W;
   localparam logic [RXC_W-1:0] RXC_LAST = RXC_W'(RX_DEPTH - 1);
   localparam logic [TXP_W-1:0] TXP_LAST = TXP_W'(TX_DEPTH - 1);

   // Configuration
   logic [uqr_pkg::TPB_W-1:0] tpb_ff;
   logic [uqr_pkg::TMO_W-1:0] tmo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tpb_ff <= uqr_pkg::TPB_RESET;
         tmo_ff <= uqr_pkg::TMO_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            uqr_pkg::CSR_TICKS_PER_BIT: tpb_ff <= csr_data[uqr_pkg::TPB_W-1:0];
            uqr_pkg::CSR_TIMEOUT_TICKS: tmo_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Tick state
   logic                        rx_in_ff;
   logic                        rx_prev_ff, rx_prev_in;
   uqr_pkg::phase_type          rx_phase_ff, rx_phase_in;
   logic [uqr_pkg::TPB_W-1:0]   rx_cd_ff, rx_cd_in;
   logic [2:0]                  rx_bit_ff, rx_bit_in;
   logic [7:0]                  rx_shift_ff, rx_shift_in;
   logic [RXC_W-1:0]            rx_count_ff, rx_count_in;
   logic [uqr_pkg::TMO_W-1:0]   tmo_cnt_ff, tmo_cnt_in;
   logic                        rx_wr;
   logic [7:0]                  rx_store_ff [uqr_pkg::MAX_MSG_BYTES];
   logic                        tx_line_ff, tx_line_in;
   uqr_pkg::phase_type          tx_phase_ff, tx_phase_in;
   logic [uqr_pkg::TPB_W-1:0]   tx_cd_ff, tx_cd_in;
   logic [2:0]                  tx_bit_ff, tx_bit_in;
   logic                        tx_par_ff, tx_par_in;
   logic [TXP_W-1:0]            tx_rp_ff, tx_rp_in;
   logic [TXP_W-1:0]            tx_wp_ff;
   logic                        tx_rewind;
   logic [7:0]                  tx_mem [TX_DEPTH];
   logic [7:0]                  tx_rd_ff;
   logic                        got_in;

   // Match state
   logic [uqr_pkg::QI_W-1:0]    qi_ff;
   logic [uqr_pkg::MJ_W-1:0]    rj_ff;
   logic                        matched_ff, longer_ff;
   logic                        got_ff, queued_ff, tx_out_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_tx_ff, rsp_got_ff, rsp_queued_ff;

   logic [uqr_pkg::LEN_W-1:0]   q_len, r_len;
   logic                        bytes_eq;
   logic                        clear_rx;

   // One tick of receiver, transmitter and timeout
   always_comb begin
      logic [uqr_pkg::TPB_W-1:0] rcd, tcd;
      logic                      rx, bit_val;
      rcd = (rx_cd_ff != '0) ? rx_cd_ff - 1'b1 : rx_cd_ff;
      tcd = (tx_cd_ff != '0) ? tx_cd_ff - 1'b1 : tx_cd_ff;
      rx  = rx_in_ff;
      rx_prev_in  = rx;
      rx_phase_in = rx_phase_ff;
      rx_cd_in    = rcd;
      rx_bit_in   = rx_bit_ff;
      rx_shift_in = rx_shift_ff;
      rx_count_in = rx_count_ff;
      tmo_cnt_in  = (tmo_cnt_ff != '0) ? tmo_cnt_ff - 1'b1 : tmo_cnt_ff;
      rx_wr       = 1'b0;
      got_in      = 1'b0;
      if (rcd == '0) begin
         case (rx_phase_ff)
            uqr_pkg::PH_IDLE: begin
               if (!rx && rx_prev_ff) begin
                  rx_phase_in = uqr_pkg::PH_START;
                  rx_cd_in    = uqr_pkg::TPB_W'(1);
               end
            end
            uqr_pkg::PH_START: begin
               if (!rx) begin
                  rx_phase_in = uqr_pkg::PH_DATA;
                  rx_bit_in   = 3'd0;
                  rx_shift_in = 8'h00;
                  rx_cd_in    = tpb_ff;
                  if (tmo_cnt_in == '0) begin
                     tmo_cnt_in = tmo_ff;
                  end
               end else begin
                  rx_phase_in = uqr_pkg::PH_IDLE;
                  rx_cd_in    = '0;
               end
            end
            uqr_pkg::PH_DATA: begin
               rx_shift_in[rx_bit_ff] = rx;
               rx_cd_in = tpb_ff;
               if (rx_bit_ff == 3'd7) begin
                  rx_bit_in   = 3'd0;
                  rx_phase_in = uqr_pkg::PH_PARITY;
                  rx_wr       = 1'b1;
                  rx_count_in = (rx_count_ff == RXC_LAST) ? '0 : rx_count_ff + 1'b1;
                  got_in      = 1'b1;
               end else begin
                  rx_bit_in = rx_bit_ff + 1'b1;
               end
            end
            uqr_pkg::PH_PARITY: begin
               rx_phase_in = uqr_pkg::PH_STOP;
               rx_cd_in    = tpb_ff;
            end
            default: begin
               rx_phase_in = uqr_pkg::PH_IDLE;
               rx_cd_in    = '0;
            end
         endcase
      end

      tx_line_in  = tx_line_ff;
      tx_phase_in = tx_phase_ff;
      tx_cd_in    = tcd;
      tx_bit_in   = tx_bit_ff;
      tx_par_in   = tx_par_ff;
      tx_rp_in    = tx_rp_ff;
      tx_rewind   = 1'b0;
      bit_val     = tx_rd_ff[tx_bit_ff];
      if (tcd == '0) begin
         tx_cd_in = tpb_ff;
         case (tx_phase_ff)
            uqr_pkg::PH_START: begin
               tx_line_in  = 1'b0;
               tx_bit_in   = 3'd0;
               tx_par_in   = 1'b0;
               tx_phase_in = uqr_pkg::PH_DATA;
            end
            uqr_pkg::PH_DATA: begin
               tx_line_in = bit_val;
               tx_par_in  = tx_par_ff ^ bit_val;
               if (tx_bit_ff == 3'd7) begin
                  tx_bit_in   = 3'd0;
                  tx_phase_in = uqr_pkg::PH_PARITY;
                  tx_rp_in    = (tx_rp_ff == TXP_LAST) ? '0 : tx_rp_ff + 1'b1;
               end else begin
                  tx_bit_in = tx_bit_ff + 1'b1;
               end
            end
            uqr_pkg::PH_PARITY: begin
               tx_line_in  = tx_par_ff;
               tx_phase_in = uqr_pkg::PH_STOP;
            end
            default: begin
               tx_line_in  = 1'b1;
               tx_phase_in = uqr_pkg::PH_IDLE;
            end
         endcase
      end
      // Start the next queued byte, or rewind an empty queue
      if (tx_phase_in == uqr_pkg::PH_IDLE) begin
         if (tx_rp_in < tx_wp_ff) begin
            tx_phase_in = uqr_pkg::PH_START;
         end else begin
            tx_rp_in  = '0;
            tx_rewind = 1'b1;
         end
      end
   end

   // Compare the current query against the stored prefix
   always_comb begin
      q_len    = uqr_pkg::QRY_LEN[qi_ff];
      r_len    = uqr_pkg::RSP_LEN[qi_ff];
      bytes_eq = 1'b1;
      for (int k = 0; k < uqr_pkg::MAX_MSG_BYTES; k++) begin
         if ((uqr_pkg::LEN_W'(k) < q_len) &&
             (rx_store_ff[k] != uqr_pkg::QRY_BYTES[qi_ff][k])) begin
            bytes_eq = 1'b0;
         end
      end
      status.rsp_free  = !rsp_valid_ff || rsp_ready;
      status.match_req = (rx_phase_ff == uqr_pkg::PH_IDLE) && (rx_count_ff != '0);
      status.q_short   = CMP_W'(rx_count_ff) < CMP_W'(q_len);
      status.q_hit     = !status.q_short && bytes_eq;
      status.q_fit     = SUM_W'(TX_DEPTH - 1) > (SUM_W'(tx_wp_ff) + SUM_W'(r_len));
      status.q_last    = qi_ff == uqr_pkg::QI_W'(uqr_pkg::NUM_QUERIES - 1);
      status.app_last  = (uqr_pkg::LEN_W'(rj_ff) + 1'b1) == r_len;
      clear_rx = status.match_req && (matched_ff || !longer_ff || tmo_cnt_ff == '0);
   end

   // Tick state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_prev_ff  <= 1'b0;
         rx_phase_ff <= uqr_pkg::PH_IDLE;
         rx_cd_ff    <= '0;
         rx_bit_ff   <= '0;
         rx_count_ff <= '0;
         tmo_cnt_ff  <= '0;
         tx_line_ff  <= 1'b1;
         tx_phase_ff <= uqr_pkg::PH_IDLE;
         tx_cd_ff    <= '0;
         tx_bit_ff   <= '0;
         tx_par_ff   <= 1'b0;
         tx_rp_ff    <= '0;
         tx_wp_ff    <= '0;
      end else if (cmd.step) begin
         rx_prev_ff  <= rx_prev_in;
         rx_phase_ff <= rx_phase_in;
         rx_cd_ff    <= rx_cd_in;
         rx_bit_ff   <= rx_bit_in;
         rx_count_ff <= rx_count_in;
         tmo_cnt_ff  <= tmo_cnt_in;
         tx_line_ff  <= tx_line_in;
         tx_phase_ff <= tx_phase_in;
         tx_cd_ff    <= tx_cd_in;
         tx_bit_ff   <= tx_bit_in;
         tx_par_ff   <= tx_par_in;
         tx_rp_ff    <= tx_rp_in;
         if (tx_rewind) begin
            tx_wp_ff <= '0;
         end
      end else if (cmd.append) begin
         tx_wp_ff <= (tx_wp_ff == TXP_LAST) ? '0 : tx_wp_ff + 1'b1;
      end else if (cmd.finish && clear_rx) begin
         rx_count_ff <= '0;
         tmo_cnt_ff  <= '0;
      end
   end

   // Assembling byte and the prefix store
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rx_in_ff <= req_rx_level;
      end
      if (cmd.step) begin
         rx_shift_ff <= rx_shift_in;
         for (int k = 0; k < uqr_pkg::MAX_MSG_BYTES; k++) begin
            if (rx_wr && CMP_W'(rx_count_ff) == CMP_W'(k)) begin
               rx_store_ff[k] <= rx_shift_in;
            end
         end
      end
   end

   // Transmit queue memory
   always_ff @(posedge clock) begin
      if (cmd.append) begin
         tx_mem[tx_wp_ff] <= uqr_pkg::RSP_BYTES[qi_ff][rj_ff];
      end
      if (cmd.fetch) begin
         tx_rd_ff <= tx_mem[tx_rp_ff];
      end
   end

   // Query scan
   always_ff @(posedge clock) begin
      if (reset) begin
         qi_ff      <= '0;
         rj_ff      <= '0;
         matched_ff <= 1'b0;
         longer_ff  <= 1'b0;
         got_ff     <= 1'b0;
         queued_ff  <= 1'b0;
         tx_out_ff  <= 1'b1;
      end else if (cmd.step) begin
         qi_ff      <= '0;
         rj_ff      <= '0;
         matched_ff <= 1'b0;
         longer_ff  <= 1'b0;
         got_ff     <= got_in;
         queued_ff  <= 1'b0;
         tx_out_ff  <= tx_line_ff;
      end else if (cmd.eval) begin
         if (status.q_short) begin
            longer_ff <= 1'b1;
         end
         if (status.q_hit) begin
            matched_ff <= 1'b1;
         end else if (!status.q_last) begin
            qi_ff <= qi_ff + 1'b1;
         end
      end else if (cmd.append) begin
         rj_ff <= rj_ff + 1'b1;
         if (status.app_last) begin
            queued_ff <= 1'b1;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_tx_ff     <= tx_out_ff;
         rsp_got_ff    <= got_ff;
         rsp_queued_ff <= queued_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tx_level      = rsp_tx_ff;
   assign rsp_byte_received = rsp_got_ff;
   assign rsp_reply_queued  = rsp_queued_ff;

endmodule
`default_nettype wire

[rtl/uart_query_responder.sv]
// A tick transaction steps through accept, fetch, step, the query scan, the reply copy and finish.
// A new tick is accepted only back in idle with the result register free, so ticks never overlap.
// The transmit queue is one memory port, read once each tick and written once per reply byte queued.
// Reset (synchronous, active high) idles both lines and empties both buffers.
`timescale 1ns / 1ps
`default_nettype none
module uart_query_responder #(
   parameter int RX_DEPTH = uqr_pkg::RX_DEPTH_DEF,
   parameter int TX_DEPTH = uqr_pkg::TX_DEPTH_DEF
) (
   input wire logic clock,
   input wire logic reset,
   uqr_req_if.sink   req_ch,
   uqr_rsp_if.source rsp_ch,
   uqr_csr_if.sink   csr_ch
);

   uqr_pkg::cmd_type    cmd;
   uqr_pkg::status_type status;

   assign csr_ch.ready = 1'b1;

   uqr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   uqr_dpath #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_rx_level      (req_ch.rx_level),
      .rsp_valid         (rsp_ch.valid),
      .rsp_ready         (rsp_ch.ready),
      .rsp_tx_level      (rsp_ch.tx_level),
      .rsp_byte_received (rsp_ch.byte_received),
      .rsp_reply_queued  (rsp_ch.reply_queued),
      .csr_valid         (csr_ch.valid),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data)
   );

endmodule
`default_nettype wire

[rtl/uqr_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "uart_query_responder_macros.svh"
module uqr_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_byte_received,
   input wire logic rsp_reply_queued
);

   // A result waiting for the sink holds
   `UQR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped while stalled")

   // A new transaction never overruns a pending result
   `UQR_ASSERT_NOW(a_no_overrun, req_valid && req_ready, !rsp_valid || rsp_ready, "req taken over pending rsp")

   // The block works one tick at a time
   `UQR_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready, "req ready right after accept")

   // A reply cannot be queued on the tick that completes a byte
   `UQR_ASSERT_NOW(a_excl, rsp_valid && rsp_reply_queued, !rsp_byte_received, "reply queued with byte")

endmodule

bind uart_query_responder uqr_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_byte_received (rsp_ch.byte_received),
   .rsp_reply_queued  (rsp_ch.reply_queued)
);
`default_nettype wire
